// ===== src/ape_pkg.sv =====
// ape_pkg: shared types and constants of the axis projection extent block
// holds configuration, queue entry and result types plus register index codes
// no dependencies
package ape_pkg;

    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_AXIS_PT_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_AXIS_PT_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_AXIS_PT_Z  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_AXIS_DIR_X = 3'd3;
    localparam logic [CFG_AW-1:0] REG_AXIS_DIR_Y = 3'd4;
    localparam logic [CFG_AW-1:0] REG_AXIS_DIR_Z = 3'd5;
    localparam logic [CFG_AW-1:0] REG_INV_NORM   = 3'd6;

    localparam logic signed [31:0] DIR_Z_RST = 32'sh0001_0000;
    localparam logic [31:0]        INV_RST   = 32'h0001_0000;

    localparam logic signed [31:0] Q_MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN32 = 32'sh8000_0000;
    localparam logic signed [47:0] DOT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] DOT_MIN = 48'sh8000_0000_0000;
    localparam logic signed [64:0] HI_POS  = 65'sd281474976710656;
    localparam logic signed [64:0] HI_NEG  = -65'sd281474976710656;
    localparam logic [30:0]        EXT_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [31:0]        inv;
    } t_axis_cfg;

    typedef struct packed {
        logic signed [31:0] t;
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] proj_z;
        logic               last;
    } t_mid_item;

    typedef struct packed {
        logic [30:0]        extent;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
    } t_result;

endpackage

// ===== src/ape_fifo.sv =====
// ape_fifo: small first-in first-out queue with flop storage and a registered head
// caller guards against overflow and underflow; no package dependency
module ape_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_head;
    logic             r_head_vld;
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wptr;
    logic [AW-1:0]    n_rptr;
    logic             load;
    logic             mem_rd;
    logic             mem_wr;

    always_comb begin
        n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        // head refills from storage, or straight from the write port when storage is empty
        load   = !r_head_vld || i_rd;
        mem_rd = load && (r_cnt != '0);
        mem_wr = i_wr && !(load && (r_cnt == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
            r_head_vld <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_wptr <= n_wptr;
            end
            if (mem_rd) begin
                r_rptr <= n_rptr;
            end
            r_cnt <= r_cnt + CW'(mem_wr) - CW'(mem_rd);
            if (load) begin
                r_head_vld <= mem_rd || i_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (mem_rd) begin
            r_head <= r_mem[r_rptr];
        end else if (load && i_wr) begin
            r_head <= i_wdata;
        end
    end

    assign o_rdata = r_head;
    assign o_empty = !r_head_vld;

endmodule

// ===== src/ape_front.sv =====
// ape_front: accepts points and computes axis position and projection
// eight-stage pipeline feeding the middle queue under a credit count; uses ape_pkg
module ape_front #(
    parameter int MQ_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    input  logic                i_last_point,
    input  ape_pkg::t_axis_cfg  i_cfg,
    input  logic                i_mq_pop,
    output logic                o_mq_wr,
    output ape_pkg::t_mid_item  o_mq_item
);
    import ape_pkg::*;

    localparam int CW   = $clog2(MQ_DEPTH + 1);
    localparam int NSTG = 8;

    logic signed [31:0] pt   [3];
    logic signed [31:0] dir  [3];
    logic signed [31:0] pnt  [3];
    logic               accept;

    logic [CW-1:0]      r_credit;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    r_last;
    logic signed [32:0] r_diff [3];
    logic signed [64:0] r_prod [3];
    logic signed [47:0] r_dot;
    logic signed [64:0] r_hi;
    logic signed [64:0] r_lo;
    logic signed [49:0] r_hic;
    logic signed [47:0] r_los;
    logic signed [31:0] r_t;
    logic signed [31:0] r_t6;
    logic signed [31:0] r_t7;
    logic signed [63:0] r_td   [3];
    logic signed [31:0] r_proj [3];

    logic signed [47:0] n_dot;
    logic signed [49:0] n_hic;
    logic signed [31:0] n_t;
    logic signed [31:0] n_proj [3];
    logic signed [50:0] dot_sum;
    logic signed [50:0] t_sum;
    logic signed [48:0] proj_sum [3];

    assign pt[0]  = i_cfg.pt_x;
    assign pt[1]  = i_cfg.pt_y;
    assign pt[2]  = i_cfg.pt_z;
    assign dir[0] = i_cfg.dir_x;
    assign dir[1] = i_cfg.dir_y;
    assign dir[2] = i_cfg.dir_z;
    assign pnt[0] = i_point_x;
    assign pnt[1] = i_point_y;
    assign pnt[2] = i_point_z;

    assign full   = (r_credit == '0);
    assign accept = push && !full;

    // one queue slot is reserved per accepted point until the back end drains it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CW'(MQ_DEPTH);
            r_vld    <= '0;
        end else begin
            r_credit <= r_credit + CW'(i_mq_pop) - CW'(accept);
            r_vld    <= {r_vld[NSTG-2:0], accept};
        end
    end

    always_comb begin
        dot_sum = 51'($signed(r_prod[0][64:16])) + 51'($signed(r_prod[1][64:16]))
                + 51'($signed(r_prod[2][64:16]));
        if (dot_sum[50:47] == {4{dot_sum[50]}}) begin
            n_dot = dot_sum[47:0];
        end else begin
            n_dot = dot_sum[50] ? DOT_MIN : DOT_MAX;
        end

        if (r_hi > HI_POS) begin
            n_hic = HI_POS[49:0];
        end else if (r_hi < HI_NEG) begin
            n_hic = HI_NEG[49:0];
        end else begin
            n_hic = r_hi[49:0];
        end

        t_sum = 51'(r_hic) + 51'(r_los);
        if (t_sum[50:31] == {20{t_sum[50]}}) begin
            n_t = t_sum[31:0];
        end else begin
            n_t = t_sum[50] ? Q_MIN32 : Q_MAX32;
        end

        for (int i = 0; i < 3; i++) begin
            proj_sum[i] = 49'(pt[i]) + 49'($signed(r_td[i][63:16]));
            if (proj_sum[i][48:31] == {18{proj_sum[i][48]}}) begin
                n_proj[i] = proj_sum[i][31:0];
            end else begin
                n_proj[i] = proj_sum[i][48] ? Q_MIN32 : Q_MAX32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[NSTG-2:0], i_last_point};
        for (int i = 0; i < 3; i++) begin
            r_diff[i] <= $signed({pnt[i][31], pnt[i]}) - $signed({pt[i][31], pt[i]});
            r_prod[i] <= r_diff[i] * dir[i];
            r_td[i]   <= r_t * dir[i];
            r_proj[i] <= n_proj[i];
        end
        r_dot <= n_dot;
        // inverse norm split into integer and fraction halves
        r_hi  <= r_dot * $signed({1'b0, i_cfg.inv[31:16]});
        r_lo  <= r_dot * $signed({1'b0, i_cfg.inv[15:0]});
        r_hic <= n_hic;
        r_los <= $signed(r_lo[63:16]);
        r_t   <= n_t;
        r_t6  <= r_t;
        r_t7  <= r_t6;
    end

    assign o_mq_wr          = r_vld[NSTG-1];
    assign o_mq_item.t      = r_t7;
    assign o_mq_item.proj_x = r_proj[0];
    assign o_mq_item.proj_y = r_proj[1];
    assign o_mq_item.proj_z = r_proj[2];
    assign o_mq_item.last   = r_last[NSTG-1];

endmodule

// ===== src/ape_back.sv =====
// ape_back: tracks axis extremes per cloud and forms extent and center
// drains the middle queue, reserves result queue space per cloud; uses ape_pkg
module ape_back #(
    parameter int OQ_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mq_empty,
    input  ape_pkg::t_mid_item  i_mq_item,
    output logic                o_mq_pop,
    input  logic                i_oq_pop,
    output logic                o_res_wr,
    output ape_pkg::t_result    o_res
);
    import ape_pkg::*;

    localparam int CW = $clog2(OQ_DEPTH + 1);

    logic signed [31:0] proj [3];
    logic               take;
    logic               upd_max;
    logic               upd_min;

    logic [CW-1:0]      r_ocred;
    logic               r_seen;
    logic               r_fin_vld;
    logic signed [31:0] r_pos_min;
    logic signed [31:0] r_pos_max;
    logic signed [31:0] r_pmin [3];
    logic signed [31:0] r_pmax [3];
    logic signed [31:0] r_fin_min;
    logic signed [31:0] r_fin_max;
    logic signed [31:0] r_fin_pmin [3];
    logic signed [31:0] r_fin_pmax [3];

    logic signed [31:0] n_pos_min;
    logic signed [31:0] n_pos_max;
    logic signed [31:0] n_pmin [3];
    logic signed [31:0] n_pmax [3];

    logic signed [32:0] ext;
    logic signed [32:0] csum [3];

    assign proj[0] = i_mq_item.proj_x;
    assign proj[1] = i_mq_item.proj_y;
    assign proj[2] = i_mq_item.proj_z;

    // a closing point waits until the result queue has a free slot
    assign take     = !i_mq_empty && (!i_mq_item.last || (r_ocred != '0));
    assign o_mq_pop = take;

    always_comb begin
        upd_max   = !r_seen || (i_mq_item.t > r_pos_max);
        upd_min   = !r_seen || (i_mq_item.t < r_pos_min);
        n_pos_max = upd_max ? i_mq_item.t : r_pos_max;
        n_pos_min = upd_min ? i_mq_item.t : r_pos_min;
        for (int i = 0; i < 3; i++) begin
            n_pmax[i] = upd_max ? proj[i] : r_pmax[i];
            n_pmin[i] = upd_min ? proj[i] : r_pmin[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocred   <= CW'(OQ_DEPTH);
            r_seen    <= 1'b0;
            r_fin_vld <= 1'b0;
        end else begin
            r_ocred   <= r_ocred - CW'(take && i_mq_item.last) + CW'(i_oq_pop);
            r_fin_vld <= take && i_mq_item.last;
            if (take) begin
                r_seen <= !i_mq_item.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pos_max <= n_pos_max;
            r_pos_min <= n_pos_min;
            r_pmax    <= n_pmax;
            r_pmin    <= n_pmin;
        end
        if (take && i_mq_item.last) begin
            r_fin_max  <= n_pos_max;
            r_fin_min  <= n_pos_min;
            r_fin_pmax <= n_pmax;
            r_fin_pmin <= n_pmin;
        end
    end

    // max never falls below min within a cloud, so the span is non-negative
    always_comb begin
        ext = 33'(r_fin_max) - 33'(r_fin_min);
        for (int i = 0; i < 3; i++) begin
            csum[i] = 33'(r_fin_pmin[i]) + 33'(r_fin_pmax[i]);
        end
    end

    assign o_res_wr       = r_fin_vld;
    assign o_res.extent   = (ext[32:31] != 2'b00) ? EXT_MAX : ext[30:0];
    assign o_res.center_x = csum[0][32:1];
    assign o_res.center_y = csum[1][32:1];
    assign o_res.center_z = csum[2][32:1];

endmodule

// ===== src/axis_projection_extent.sv =====
// axis_projection_extent: extent and center of a point cloud along an axis line
// result path: an accepted last point reaches the ports through the
//   eight-stage projection pipeline, the middle queue, the extreme update and the result queue
// throughput: one point per cycle unless full; eight-stage pipeline, registered extreme update
// reset: synchronous active-low; clears queues and cloud state, loads register defaults
// uses ape_pkg, ape_front, ape_back, ape_fifo
module axis_projection_extent #(
    parameter int MQ_DEPTH = 16,
    parameter int OQ_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ape_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic signed [31:0]          i_point_x,
    input  logic signed [31:0]          i_point_y,
    input  logic signed [31:0]          i_point_z,
    input  logic                        i_last_point,
    output logic                        empty,
    input  logic                        pop,
    output logic [30:0]                 o_extent_height,
    output logic signed [31:0]          o_center_x,
    output logic signed [31:0]          o_center_y,
    output logic signed [31:0]          o_center_z
);
    import ape_pkg::*;

    t_axis_cfg  r_cfg;
    t_mid_item  mq_wdata;
    t_mid_item  mq_rdata;
    t_result    res;
    t_result    oq_rdata;
    logic       mq_wr;
    logic       mq_pop;
    logic       mq_empty;
    logic       res_wr;
    logic       oq_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pt_x  <= '0;
            r_cfg.pt_y  <= '0;
            r_cfg.pt_z  <= '0;
            r_cfg.dir_x <= '0;
            r_cfg.dir_y <= '0;
            r_cfg.dir_z <= DIR_Z_RST;
            r_cfg.inv   <= INV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_AXIS_PT_X:  r_cfg.pt_x  <= i_cfg_data;
                REG_AXIS_PT_Y:  r_cfg.pt_y  <= i_cfg_data;
                REG_AXIS_PT_Z:  r_cfg.pt_z  <= i_cfg_data;
                REG_AXIS_DIR_X: r_cfg.dir_x <= i_cfg_data;
                REG_AXIS_DIR_Y: r_cfg.dir_y <= i_cfg_data;
                REG_AXIS_DIR_Z: r_cfg.dir_z <= i_cfg_data;
                REG_INV_NORM:   r_cfg.inv   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ape_front #(
        .MQ_DEPTH (MQ_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_last_point (i_last_point),
        .i_cfg        (r_cfg),
        .i_mq_pop     (mq_pop),
        .o_mq_wr      (mq_wr),
        .o_mq_item    (mq_wdata)
    );

    ape_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mq_wr),
        .i_wdata (mq_wdata),
        .i_rd    (mq_pop),
        .o_rdata (mq_rdata),
        .o_empty (mq_empty)
    );

    ape_back #(
        .OQ_DEPTH (OQ_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_empty (mq_empty),
        .i_mq_item  (mq_rdata),
        .o_mq_pop   (mq_pop),
        .i_oq_pop   (oq_pop),
        .o_res_wr   (res_wr),
        .o_res      (res)
    );

    assign oq_pop = pop && !empty;

    ape_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res),
        .i_rd    (oq_pop),
        .o_rdata (oq_rdata),
        .o_empty (empty)
    );

    assign o_extent_height = oq_rdata.extent;
    assign o_center_x      = oq_rdata.center_x;
    assign o_center_y      = oq_rdata.center_y;
    assign o_center_z      = oq_rdata.center_z;

endmodule
